@@ hdl/mlsm_pkg.sv @@
// ----------------------------------------------------------------------------
// mlsm_pkg
// Shared types, constants and the ladder step sequence for the X25519
// Montgomery ladder block.
// ----------------------------------------------------------------------------
package mlsm_pkg;

	localparam int FE_W  = 255;
	localparam int ACC_W = 257;
	localparam int POS_W = 8;

	// 2^255 - 19
	localparam logic [255:0] P_MOD = {1'b0, {250{1'b1}}, 5'b01101};
	localparam logic [254:0] A24_K = 255'd121666;

	typedef enum logic [1:0] {
		ALU_ADD,
		ALU_SUB,
		ALU_MUL,
		ALU_CANON
	} alu_op_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_ctrl_t;

	typedef enum logic [1:0] {
		A_IDLE,
		A_MUL,
		A_FOLD,
		A_FIX
	} alu_state_t;

	typedef enum logic [2:0] {
		R_X1,
		R_X2,
		R_Z2,
		R_X3,
		R_Z3,
		R_T0,
		R_T1,
		R_KC
	} reg_id_t;

	typedef struct packed {
		alu_op_t op;
		reg_id_t a;
		reg_id_t b;
		reg_id_t d;
	} step_op_t;

	localparam logic [4:0] OP_LAST = 5'd17;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CFETCH,
		ST_CSTART,
		ST_CWAIT,
		ST_INIT,
		ST_BITRD,
		ST_BITCAP,
		ST_OPRD,
		ST_OPGO,
		ST_OPWAIT,
		ST_ORD,
		ST_OLAT,
		ST_OEMIT
	} top_state_t;

	// one ladder step, in logical register names
	function automatic step_op_t step_op(logic [4:0] idx);
		step_op_t o;
		unique case (idx)
			5'd0:    o = '{ALU_SUB, R_X3, R_Z3, R_T0};
			5'd1:    o = '{ALU_SUB, R_X2, R_Z2, R_T1};
			5'd2:    o = '{ALU_ADD, R_X2, R_Z2, R_X2};
			5'd3:    o = '{ALU_ADD, R_X3, R_Z3, R_Z2};
			5'd4:    o = '{ALU_MUL, R_T0, R_X2, R_Z3};
			5'd5:    o = '{ALU_MUL, R_Z2, R_T1, R_Z2};
			5'd6:    o = '{ALU_MUL, R_T1, R_T1, R_T0};
			5'd7:    o = '{ALU_MUL, R_X2, R_X2, R_T1};
			5'd8:    o = '{ALU_ADD, R_Z3, R_Z2, R_X3};
			5'd9:    o = '{ALU_SUB, R_Z3, R_Z2, R_Z2};
			5'd10:   o = '{ALU_MUL, R_T1, R_T0, R_X2};
			5'd11:   o = '{ALU_SUB, R_T1, R_T0, R_T1};
			5'd12:   o = '{ALU_MUL, R_Z2, R_Z2, R_Z2};
			5'd13:   o = '{ALU_MUL, R_T1, R_KC, R_Z3};
			5'd14:   o = '{ALU_MUL, R_X3, R_X3, R_X3};
			5'd15:   o = '{ALU_ADD, R_T0, R_Z3, R_T0};
			5'd16:   o = '{ALU_MUL, R_X1, R_Z2, R_Z3};
			default: o = '{ALU_MUL, R_T1, R_T0, R_Z2};
		endcase
		return o;
	endfunction

	// the conditional swap is an address swap keyed by the current scalar bit
	function automatic reg_id_t map_reg(reg_id_t r, logic b);
		reg_id_t m;
		m = r;
		if (b) begin
			if (r == R_X2) m = R_X3;
			else if (r == R_X3) m = R_X2;
			else if (r == R_Z2) m = R_Z3;
			else if (r == R_Z3) m = R_Z2;
		end
		return m;
	endfunction

endpackage

@@ hdl/mlsm_field_alu.sv @@
// ----------------------------------------------------------------------------
// mlsm_field_alu
// Arithmetic modulo 2^255-19: add, subtract, multiply and canonical reduce.
// Multiply is word-serial, most significant 32-bit word of a first.
// ----------------------------------------------------------------------------
module mlsm_field_alu
	import mlsm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  alu_ctrl_t         ctrl,
	input  logic [FE_W-1:0]   a,
	input  logic [FE_W-1:0]   b,
	output logic              done,
	output logic [FE_W-1:0]   res
);

	alu_state_t         state_q, state_d;
	logic [3:0]         cnt_q;
	logic               done_q;
	logic [255:0]       a_q, b_q;
	logic [ACC_W-1:0]   acc_q;
	logic [255:0]       fold_q;
	logic [FE_W-1:0]    res_q;
	logic [255:0]       even_s1, odd_s1;
	logic [31:0]        a_word;
	logic [63:0]        prod [8];
	logic [290:0]       sum_t;
	logic [40:0]        hi38;
	logic [ACC_W-1:0]   acc_next;
	logic [255:0]       fold_v;
	logic [255:0]       fix_v;
	logic [5:0]         top19;

	assign a_word = a_q[32*(3'(4'd7 - cnt_q)) +: 32];

	for (genvar g = 0; g < 8; g++) begin : g_lane
		assign prod[g] = a_word * b_q[32*g +: 32];
	end

	// acc*2^32 + a_i*b, bits from 2^256 folded back in as *38
	always_comb begin
		sum_t = {2'b0, acc_q, 32'b0} + {35'b0, even_s1} + {3'b0, odd_s1, 32'b0};
		hi38 = {1'b0, sum_t[290:256], 5'b0} + {4'b0, sum_t[290:256], 2'b0}
			+ {5'b0, sum_t[290:256], 1'b0};
		acc_next = {1'b0, sum_t[255:0]} + {216'b0, hi38};
		top19 = {acc_q[256:255], 4'b0} + {3'b0, acc_q[256:255], 1'b0}
			+ {4'b0, acc_q[256:255]};
		fold_v = {1'b0, acc_q[254:0]} + {250'b0, top19};
		fix_v = fold_q + 256'd19;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			A_IDLE: begin
				if (ctrl.start) state_d = (ctrl.op == ALU_MUL) ? A_MUL : A_FOLD;
			end
			A_MUL: begin
				if (cnt_q == 4'd8) state_d = A_FOLD;
			end
			A_FOLD:  state_d = A_FIX;
			A_FIX:   state_d = A_IDLE;
			default: state_d = A_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == A_FIX);
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			A_IDLE: begin
				a_q   <= {1'b0, a};
				b_q   <= {1'b0, b};
				cnt_q <= 4'd0;
				unique case (ctrl.op)
					ALU_ADD:   acc_q <= {2'b0, a} + {2'b0, b};
					ALU_SUB:   acc_q <= {2'b0, a} + {1'b0, P_MOD} - {2'b0, b};
					ALU_MUL:   acc_q <= '0;
					default:   acc_q <= {2'b0, a};
				endcase
			end
			A_MUL: begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q != 4'd8) begin
					for (int k = 0; k < 4; k++) begin
						even_s1[64*k +: 64] <= prod[2*k];
						odd_s1[64*k +: 64]  <= prod[2*k+1];
					end
				end
				if (cnt_q != 4'd0) acc_q <= acc_next;
			end
			A_FOLD: fold_q <= fold_v;
			A_FIX:  res_q <= fix_v[255] ? fix_v[254:0] : fold_q[254:0];
			default: ;
		endcase
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

@@ hdl/montgomery_ladder_scalar_mult.sv @@
// ----------------------------------------------------------------------------
// montgomery_ladder_scalar_mult
// X25519 differential ladder without clamping, eight-word load, sixteen-word
// canonical projective result.
// ----------------------------------------------------------------------------
// Load words are taken one per cycle while the block is idle. The word marked
// start_ladder starts a run: the coordinate is fetched and reduced, six
// working registers are set up, then each of the LADDER_TOP_BIT+1 ladder
// steps fetches the scalar bit and runs ten multiplications and eight
// additions and subtractions. The multiplier forms one 32 by 256 bit row a
// cycle. After the run the sixteen result words leave, four per field
// element; the words of one element leave one per cycle when not stalled.
// No load word is taken from the start of a run until the last result is
// registered.
// ----------------------------------------------------------------------------
module montgomery_ladder_scalar_mult
	import mlsm_pkg::*;
#(
	parameter int LADDER_TOP_BIT = 254
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  word_select,
	input  logic [63:0] word_value,
	input  logic        start_ladder,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  result_index,
	output logic [63:0] result_word,
	output logic        last_result
);

	top_state_t        state_q, state_d;
	logic [2:0]        cnt_q;
	logic [4:0]        op_q;
	logic [POS_W-1:0]  pos_q;
	logic              bit_q;
	logic [1:0]        elem_q, widx_q;
	logic [255:0]      coord_q;
	logic [255:0]      obuf_q;

	logic [63:0]       lm [8];
	logic [63:0]       lm_rd_q;
	logic [2:0]        lm_raddr;

	logic [FE_W-1:0]   rf [8];
	logic [FE_W-1:0]   rd_a_q, rd_b_q;
	reg_id_t           rf_ra, rf_rb, rf_wa;
	logic              rf_we;
	logic [FE_W-1:0]   rf_wd;

	alu_ctrl_t         alu_ctrl;
	logic [FE_W-1:0]   alu_a;
	logic              alu_done;
	logic [FE_W-1:0]   alu_res;

	step_op_t          cur_op;
	logic              in_xfer, emit;
	logic              out_valid_q;
	logic [3:0]        idx_q;
	logic [63:0]       word_q;
	logic              last_q;

	assign in_xfer = in_valid && !in_stall;
	assign cur_op  = step_op(op_q);
	assign alu_a   = (state_q == ST_CSTART) ? coord_q[254:0] : rd_a_q;

	mlsm_field_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (alu_ctrl),
		.a      (alu_a),
		.b      (rd_b_q),
		.done   (alu_done),
		.res    (alu_res)
	);

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		lm_raddr = 3'd0;
		rf_ra    = R_X1;
		rf_rb    = R_X1;
		rf_we    = 1'b0;
		rf_wa    = R_X1;
		rf_wd    = alu_res;
		alu_ctrl = '{start: 1'b0, op: ALU_CANON};
		emit     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid && start_ladder) state_d = ST_CFETCH;
			end
			ST_CFETCH: begin
				lm_raddr = {1'b1, cnt_q[1:0]};
				if (cnt_q == 3'd4) state_d = ST_CSTART;
			end
			ST_CSTART: begin
				alu_ctrl = '{start: 1'b1, op: ALU_CANON};
				state_d  = ST_CWAIT;
			end
			ST_CWAIT: begin
				if (alu_done) state_d = ST_INIT;
			end
			ST_INIT: begin
				rf_we = 1'b1;
				unique case (cnt_q)
					3'd0: rf_wa = R_X1;
					3'd1: rf_wa = R_X3;
					3'd2: begin rf_wa = R_X2; rf_wd = 255'd1; end
					3'd3: begin rf_wa = R_Z2; rf_wd = '0; end
					3'd4: begin rf_wa = R_Z3; rf_wd = 255'd1; end
					default: begin rf_wa = R_KC; rf_wd = A24_K; end
				endcase
				if (cnt_q == 3'd5) state_d = ST_BITRD;
			end
			ST_BITRD: begin
				lm_raddr = {1'b0, pos_q[7:6]};
				state_d  = ST_BITCAP;
			end
			ST_BITCAP: state_d = ST_OPRD;
			ST_OPRD: begin
				rf_ra   = map_reg(cur_op.a, bit_q);
				rf_rb   = map_reg(cur_op.b, bit_q);
				state_d = ST_OPGO;
			end
			ST_OPGO: begin
				alu_ctrl = '{start: 1'b1, op: cur_op.op};
				state_d  = ST_OPWAIT;
			end
			ST_OPWAIT: begin
				if (alu_done) begin
					rf_we = 1'b1;
					rf_wa = map_reg(cur_op.d, bit_q);
					if (op_q != OP_LAST) state_d = ST_OPRD;
					else if (pos_q != '0) state_d = ST_BITRD;
					else state_d = ST_ORD;
				end
			end
			ST_ORD: begin
				unique case (elem_q)
					2'd0:    rf_ra = R_X2;
					2'd1:    rf_ra = R_Z2;
					2'd2:    rf_ra = R_X3;
					default: rf_ra = R_Z3;
				endcase
				state_d = ST_OLAT;
			end
			ST_OLAT: state_d = ST_OEMIT;
			ST_OEMIT: begin
				emit = !out_valid_q || !out_stall;
				if (emit && widx_q == 2'd3) state_d = (elem_q == 2'd3) ? ST_IDLE : ST_ORD;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				cnt_q  <= 3'd0;
				elem_q <= 2'd0;
			end
			ST_CFETCH: begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q != 3'd0) coord_q <= {lm_rd_q, coord_q[255:64]};
			end
			ST_CWAIT: cnt_q <= 3'd0;
			ST_INIT: begin
				cnt_q <= cnt_q + 3'd1;
				pos_q <= POS_W'(LADDER_TOP_BIT);
			end
			ST_BITCAP: begin
				bit_q <= lm_rd_q[pos_q[5:0]];
				op_q  <= 5'd0;
			end
			ST_OPWAIT: begin
				if (alu_done) begin
					if (op_q != OP_LAST) op_q <= op_q + 5'd1;
					else if (pos_q != '0) pos_q <= pos_q - 1'b1;
				end
			end
			ST_OLAT: begin
				obuf_q <= {1'b0, rd_a_q};
				widx_q <= 2'd0;
			end
			ST_OEMIT: begin
				if (emit) begin
					widx_q <= widx_q + 2'd1;
					if (widx_q == 2'd3) elem_q <= elem_q + 2'd1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			idx_q  <= {elem_q, widx_q};
			word_q <= obuf_q[64*widx_q +: 64];
			last_q <= (elem_q == 2'd3) && (widx_q == 2'd3);
		end
	end

	// load word store
	always_ff @(posedge clk) begin
		if (in_xfer) lm[word_select] <= word_value;
		lm_rd_q <= lm[lm_raddr];
	end

	// field element register file, two read ports
	always_ff @(posedge clk) begin
		if (rf_we) rf[rf_wa] <= rf_wd;
		rd_a_q <= rf[rf_ra];
		rd_b_q <= rf[rf_rb];
	end

	assign out_valid    = out_valid_q;
	assign result_index = idx_q;
	assign result_word  = word_q;
	assign last_result  = last_q;

	a_done_when_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		alu_done |-> (state_q == ST_OPWAIT || state_q == ST_CWAIT))
		else $error("alu result with no operation waiting");

	a_ladder_keeps_consts: assert property (@(posedge clk) disable iff (!arst_n)
		(rf_we && state_q == ST_OPWAIT) |-> (rf_wa != R_X1 && rf_wa != R_KC))
		else $error("ladder step overwrote base coordinate or constant");

	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_result == (result_index == 4'd15)))
		else $error("last result flag out of step with index");

	a_emit_order: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && widx_q == 2'd3 && elem_q == 2'd3) |=> (state_q == ST_IDLE))
		else $error("result burst did not end after sixteenth word");

endmodule
